FILE: rtl/maft_pkg.sv
// ----------------------------------------------------------------------------
// maft_pkg
// shared types and codes of the mac address filter table
// ----------------------------------------------------------------------------
package maft_pkg;

    // widest slot index, in bits, that the table can have
    localparam int unsigned IDX_W_MAX = 8;

    typedef enum logic [2:0] {
        ACT_ADD        = 3'd0,
        ACT_REMOVE     = 3'd1,
        ACT_FIND       = 3'd2,
        ACT_CLEAR_ALL  = 3'd3,
        ACT_SET_FIXED  = 3'd4,
        ACT_CLR_FIXED  = 3'd5,
        ACT_GET_FIXED  = 3'd6,
        ACT_READ_ENTRY = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NOT_FOUND = 3'd1,
        STS_FULL      = 3'd2,
        STS_RANGE     = 3'd3,
        STS_NO_FIXED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_INDEX,
        S_DONE
    } state_t;

    // one stored slot, less its valid flag
    typedef struct packed {
        logic [63:0]        addr;
        logic               fixed;
        logic signed [7:0]  rssi;
    } entry_t;

    // access request from the sequencer to the slot memory
    typedef struct packed {
        logic                   rd_en;
        logic [IDX_W_MAX-1:0]   rd_addr;
        logic                   wr_en;
        logic [IDX_W_MAX-1:0]   wr_addr;
        entry_t                 wr_data;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [3:0]         slot_index;
        logic [63:0]        entry_address;
        logic signed [7:0]  entry_rssi;
        logic               entry_valid;
        logic               entry_fixed;
    } result_t;

endpackage

FILE: rtl/maft_if.sv
// ----------------------------------------------------------------------------
// maft_if
// request and result channels of the mac address filter table
// ----------------------------------------------------------------------------
interface maft_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [63:0]        ext_address;
    logic [7:0]         entry_index;
    logic signed [7:0]  rssi_value;

    modport source (output valid, output action, output ext_address,
                    output entry_index, output rssi_value, input ready);
    modport sink   (input valid, input action, input ext_address,
                    input entry_index, input rssi_value, output ready);
endinterface

interface maft_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [3:0]         slot_index;
    logic [63:0]        entry_address;
    logic signed [7:0]  entry_rssi;
    logic               entry_valid;
    logic               entry_fixed;

    modport source (output valid, output status, output slot_index,
                    output entry_address, output entry_rssi, output entry_valid,
                    output entry_fixed, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input entry_address, input entry_rssi, input entry_valid,
                    input entry_fixed, output ready);
endinterface

FILE: rtl/maft_mem.sv
// ----------------------------------------------------------------------------
// maft_mem
// slot memory: one write port, one registered read port
// ----------------------------------------------------------------------------
module maft_mem #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  maft_pkg::mem_req_t  req,
    output maft_pkg::entry_t    rd_data
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    maft_pkg::entry_t           mem [TABLE_ENTRIES];
    maft_pkg::entry_t           rd_q_reg;
    logic [TABLE_ENTRIES-1:0]   init_reg;
    logic                       rd_init_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[IW-1:0]] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_q_reg <= mem[req.rd_addr[IW-1:0]];
        end
    end

    // slots never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg    <= '0;
            rd_init_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                init_reg[req.wr_addr[IW-1:0]] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_init_reg <= init_reg[req.rd_addr[IW-1:0]];
            end
        end
    end

    assign rd_data = rd_init_reg ? rd_q_reg : '0;

endmodule

FILE: rtl/maft_ctrl.sv
// ----------------------------------------------------------------------------
// maft_ctrl
// sequencer: decodes an action, scans or addresses the slot memory,
// writes back and builds the result
// ----------------------------------------------------------------------------
module maft_ctrl #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    maft_in_if.sink             in_ch,
    output logic                res_valid,
    input  logic                res_take,
    output maft_pkg::result_t   res,
    output maft_pkg::mem_req_t  mem_req,
    input  maft_pkg::entry_t    rd_data
);

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    maft_pkg::state_t           state_reg, state_next;
    maft_pkg::action_t          op_reg, op_next, in_op;
    logic [63:0]                addr_reg, addr_next;
    logic [7:0]                 idx_reg, idx_next;
    logic signed [7:0]          rssi_reg, rssi_next;
    logic [IW-1:0]              cnt_reg, cnt_next;
    logic                       free_found_reg, free_found_next;
    logic [IW-1:0]              free_slot_reg, free_slot_next;
    logic signed [7:0]          free_rssi_reg, free_rssi_next;
    logic [TABLE_ENTRIES-1:0]   valid_reg, valid_next;
    maft_pkg::result_t          res_reg, res_next;

    logic                       in_fire;
    logic                       in_range;
    logic                       hit;
    logic                       cur_free;
    logic                       last;
    logic [IW-1:0]              slot_sel;
    logic [IW-1:0]              idx_slot;

    assign in_ch.ready = (state_reg == maft_pkg::S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_op       = maft_pkg::action_t'(in_ch.action);
    assign in_range    = ({1'b0, in_ch.entry_index} < 9'(TABLE_ENTRIES));

    assign hit      = valid_reg[cnt_reg] && (rd_data.addr == addr_reg);
    assign cur_free = !valid_reg[cnt_reg];
    assign last     = (cnt_reg == IW'(TABLE_ENTRIES - 1));
    assign slot_sel = free_found_reg ? free_slot_reg : cnt_reg;
    assign idx_slot = idx_reg[IW-1:0];

    assign res_valid = (state_reg == maft_pkg::S_DONE);
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            maft_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_op)
                        maft_pkg::ACT_ADD,
                        maft_pkg::ACT_REMOVE,
                        maft_pkg::ACT_FIND:      state_next = maft_pkg::S_SCAN;
                        maft_pkg::ACT_CLEAR_ALL: state_next = maft_pkg::S_DONE;
                        default:
                            state_next = in_range ? maft_pkg::S_INDEX : maft_pkg::S_DONE;
                    endcase
                end
            end
            maft_pkg::S_SCAN:
            begin
                if (hit || last)
                begin
                    state_next = maft_pkg::S_DONE;
                end
            end
            maft_pkg::S_INDEX:
            begin
                state_next = maft_pkg::S_DONE;
            end
            maft_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = maft_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = maft_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory requests and result
    always_comb
    begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        rssi_next       = rssi_reg;
        cnt_next        = cnt_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        free_rssi_next  = free_rssi_reg;
        valid_next      = valid_reg;
        res_next        = res_reg;
        mem_req         = '0;

        case (state_reg)
            maft_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = in_op;
                    addr_next       = in_ch.ext_address;
                    idx_next        = in_ch.entry_index;
                    rssi_next       = in_ch.rssi_value;
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                    res_next        = '0;
                    res_next.status = maft_pkg::STS_OK;
                    case (in_op)
                        maft_pkg::ACT_ADD,
                        maft_pkg::ACT_REMOVE,
                        maft_pkg::ACT_FIND:
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = '0;
                        end
                        maft_pkg::ACT_CLEAR_ALL:
                        begin
                            valid_next = '0;
                        end
                        default:
                        begin
                            if (in_range)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = in_ch.entry_index;
                            end
                            else
                            begin
                                res_next.status = maft_pkg::STS_RANGE;
                            end
                        end
                    endcase
                end
            end

            maft_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    res_next.slot_index = 4'(cnt_reg);
                    if (op_reg == maft_pkg::ACT_REMOVE)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = maft_pkg::IDX_W_MAX'(cnt_reg);
                        mem_req.wr_data = '0;
                        valid_next[cnt_reg] = 1'b0;
                    end
                end
                else if (last)
                begin
                    if (op_reg == maft_pkg::ACT_ADD)
                    begin
                        if (free_found_reg || cur_free)
                        begin
                            // claim first free slot, keep its stored rssi
                            mem_req.wr_en         = 1'b1;
                            mem_req.wr_addr       = maft_pkg::IDX_W_MAX'(slot_sel);
                            mem_req.wr_data.addr  = addr_reg;
                            mem_req.wr_data.fixed = 1'b0;
                            mem_req.wr_data.rssi  = free_found_reg ? free_rssi_reg
                                                                   : rd_data.rssi;
                            valid_next[slot_sel]  = 1'b1;
                            res_next.slot_index   = 4'(slot_sel);
                        end
                        else
                        begin
                            res_next.status = maft_pkg::STS_FULL;
                        end
                    end
                    else
                    begin
                        res_next.status = maft_pkg::STS_NOT_FOUND;
                    end
                end
                else
                begin
                    cnt_next        = cnt_reg + IW'(1);
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = maft_pkg::IDX_W_MAX'(cnt_reg + IW'(1));
                    if (!free_found_reg && cur_free)
                    begin
                        free_found_next = 1'b1;
                        free_slot_next  = cnt_reg;
                        free_rssi_next  = rd_data.rssi;
                    end
                end
            end

            maft_pkg::S_INDEX:
            begin
                res_next.slot_index = 4'(idx_slot);
                case (op_reg)
                    maft_pkg::ACT_SET_FIXED:
                    begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = idx_reg;
                        mem_req.wr_data.addr  = rd_data.addr;
                        mem_req.wr_data.fixed = 1'b1;
                        mem_req.wr_data.rssi  = rssi_reg;
                    end
                    maft_pkg::ACT_CLR_FIXED:
                    begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = idx_reg;
                        mem_req.wr_data.addr  = rd_data.addr;
                        mem_req.wr_data.fixed = 1'b0;
                        mem_req.wr_data.rssi  = rd_data.rssi;
                    end
                    maft_pkg::ACT_GET_FIXED:
                    begin
                        if (valid_reg[idx_slot] && rd_data.fixed)
                        begin
                            res_next.entry_rssi = rd_data.rssi;
                        end
                        else
                        begin
                            res_next.status = maft_pkg::STS_NO_FIXED;
                        end
                    end
                    maft_pkg::ACT_READ_ENTRY:
                    begin
                        res_next.entry_address = rd_data.addr;
                        res_next.entry_rssi    = rd_data.rssi;
                        res_next.entry_valid   = valid_reg[idx_slot];
                        res_next.entry_fixed   = rd_data.fixed;
                    end
                    default:
                    begin
                        res_next = res_reg;
                    end
                endcase
            end

            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= maft_pkg::S_IDLE;
            valid_reg      <= '0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        addr_reg      <= addr_next;
        idx_reg       <= idx_next;
        rssi_reg      <= rssi_next;
        free_slot_reg <= free_slot_next;
        free_rssi_reg <= free_rssi_next;
        res_reg       <= res_next;
    end

endmodule

FILE: rtl/mac_address_filter_table_unit.sv
// ----------------------------------------------------------------------------
// mac_address_filter_table_unit
// table of 64-bit extended mac addresses with per-slot fixed rssi
// ----------------------------------------------------------------------------
// Each request transaction carries one action and yields exactly one result
// transaction. Slots live in a single-port-read, single-port-write memory with
// a registered read port; valid flags are held in flip-flops so that clear all
// drops every valid flag at once. Add, remove and find scan the memory from
// slot 0 upward, one slot per cycle, and stop at the first valid match. The
// indexed actions read the addressed slot and, for set and clear fixed rssi,
// write it back; an index out of range skips the read. A request is taken
// only while the sequencer is idle, but the finished result sits in an output
// register, so the next request may be accepted and worked on while the
// previous result still waits on the sink; a sink that holds off ready while
// the output register is still full holds the sequencer in its done state.
// Out of reset every slot reads as zero and free; slots never written read
// back as zero.
// ----------------------------------------------------------------------------
module mac_address_filter_table_unit #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    maft_in_if.sink     in_ch,
    maft_out_if.source  out_ch
);

    maft_pkg::mem_req_t mem_req;
    maft_pkg::entry_t   rd_data;
    maft_pkg::result_t  res;
    logic               res_valid;
    logic               res_take;

    logic               out_valid_reg, out_valid_next;
    maft_pkg::result_t  out_reg;

    // slot storage
    maft_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // action sequencer and slot scan
    maft_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // output register loads when empty or being drained this cycle
    assign res_take = res_valid && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    // result transaction
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_reg.status;
    assign out_ch.slot_index    = out_reg.slot_index;
    assign out_ch.entry_address = out_reg.entry_address;
    assign out_ch.entry_rssi    = out_reg.entry_rssi;
    assign out_ch.entry_valid   = out_reg.entry_valid;
    assign out_ch.entry_fixed   = out_reg.entry_fixed;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the mac address filter table
// ----------------------------------------------------------------------------
// A short directed walk covers the corners of every action: empty table,
// indexes past the end, fixed rssi on free slots, remove and clear all. Then
// random episodes run over small address pools, so the table fills, overflows
// and empties again. A behavioural mirror of the table predicts the result
// transactions not written out in the directed rows, and the results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    import maft_pkg::*;

    localparam int unsigned SLOTS        = 16;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned QUIET_TAIL   = 200;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam logic [63:0] ADDR_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ADDR_MIXED   = 64'h0123_4567_89AB_CDEF;

    // one request, with the result written out where it is obvious
    typedef struct {
        action_t            op;
        logic [63:0]        addr;
        logic [7:0]         idx;
        logic signed [7:0]  rssi;
        bit                 fixed_reply;
        result_t            reply;
    } table_request_t;

    logic clk;
    logic rst_n;

    maft_in_if  in_ch ();
    maft_out_if out_ch ();

    mac_address_filter_table_unit #(
        .TABLE_ENTRIES (SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // mirror of the slot memory, zero out of reset
    logic [63:0]        slot_address [SLOTS] = '{default: '0};
    bit                 slot_valid   [SLOTS] = '{default: 1'b0};
    bit                 slot_fixed   [SLOTS] = '{default: 1'b0};
    logic signed [7:0]  slot_rssi    [SLOTS] = '{default: '0};

    // predicted results, oldest first
    result_t        table_replies [$];
    logic [63:0]    address_pool [$];
    int unsigned    fault_count = 0;
    int unsigned    stall_cycles = 0;
    bit             idle_on = 1'b0;

    // directed walk; rows with fixed_reply clear are left to the mirror
    table_request_t directed_rows [0:24] = '{
        // empty table reads back as zero
        '{ACT_READ_ENTRY, 64'h0,      8'd0,   8'sd0,  1'b1,
          '{STS_OK,        4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_READ_ENTRY, ADDR_ONES,  8'd255, -8'sd1, 1'b1,
          '{STS_RANGE,     4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_GET_FIXED,  64'h0,      8'd15,  8'sd0,  1'b1,
          '{STS_NO_FIXED,  4'd15, 64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_FIND,       ADDR_ONES,  8'd0,   8'sd0,  1'b1,
          '{STS_NOT_FOUND, 4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_REMOVE,     64'h0,      8'd0,   8'sd0,  1'b1,
          '{STS_NOT_FOUND, 4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        // add, then add again: no second copy
        '{ACT_ADD,        ADDR_ONES,  8'd0,   8'sd0,  1'b1,
          '{STS_OK,        4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_ADD,        ADDR_ONES,  8'd0,   8'sd0,  1'b1,
          '{STS_OK,        4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_ADD,        64'h0,      8'd0,   8'sd0,  1'b1,
          '{STS_OK,        4'd1,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_SET_FIXED,  64'h0,      8'd1,   -8'sd128, 1'b1,
          '{STS_OK,        4'd1,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_GET_FIXED,  64'h0,      8'd1,   8'sd0,  1'b1,
          '{STS_OK,        4'd1,  64'h0, -8'sd128, 1'b0, 1'b0}},
        // fixed rssi on a free slot is stored but not readable by get
        '{ACT_SET_FIXED,  64'h0,      8'd15,  8'sd127, 1'b1,
          '{STS_OK,        4'd15, 64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_GET_FIXED,  64'h0,      8'd15,  8'sd0,  1'b1,
          '{STS_NO_FIXED,  4'd15, 64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_CLR_FIXED,  64'h0,      8'd1,   8'sd0,  1'b1,
          '{STS_OK,        4'd1,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_GET_FIXED,  64'h0,      8'd1,   8'sd0,  1'b1,
          '{STS_NO_FIXED,  4'd1,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_READ_ENTRY, 64'h0,      8'd15,  8'sd0,  1'b1,
          '{STS_OK,        4'd15, 64'h0, 8'sd127,  1'b0, 1'b1}},
        // indexes just past and far past the end
        '{ACT_SET_FIXED,  64'h0,      8'd16,  8'sd5,  1'b1,
          '{STS_RANGE,     4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_CLR_FIXED,  64'h0,      8'd200, 8'sd0,  1'b1,
          '{STS_RANGE,     4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_GET_FIXED,  64'h0,      8'd16,  8'sd0,  1'b1,
          '{STS_RANGE,     4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        // remove zeroes the slot, add reuses it
        '{ACT_REMOVE,     ADDR_ONES,  8'd0,   8'sd0,  1'b1,
          '{STS_OK,        4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_ADD,        ADDR_MIXED, 8'd0,   8'sd0,  1'b0, '0},
        '{ACT_READ_ENTRY, 64'h0,      8'd1,   8'sd0,  1'b0, '0},
        // clear all keeps addresses, flags and rssi, drops valid only
        '{ACT_CLEAR_ALL,  ADDR_ONES,  8'd255, -8'sd1, 1'b1,
          '{STS_OK,        4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_FIND,       64'h0,      8'd0,   8'sd0,  1'b1,
          '{STS_NOT_FOUND, 4'd0,  64'h0, 8'sd0,    1'b0, 1'b0}},
        '{ACT_ADD,        64'h0,      8'd0,   8'sd0,  1'b0, '0},
        '{ACT_READ_ENTRY, 64'h0,      8'd1,   8'sd0,  1'b0, '0}
    };

    // first valid slot holding addr, or -1
    function automatic int lookup_slot(logic [63:0] addr);
        int hit;
        hit = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (slot_valid[i] && slot_address[i] == addr)
                hit = i;
        return hit;
    endfunction

    // applies one action to the mirror and returns the result it yields
    function automatic result_t apply_table_op(action_t op, logic [63:0] addr,
                                               logic [7:0] idx,
                                               logic signed [7:0] rssi);
        result_t res;
        int      hit;
        int      free_slot;
        res = '0;
        case (op)
            ACT_ADD:
            begin
                hit = lookup_slot(addr);
                if (hit < 0)
                begin
                    // lowest free slot; the rssi already there is kept
                    free_slot = -1;
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_valid[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        slot_address[free_slot] = addr;
                        slot_valid[free_slot]   = 1'b1;
                        slot_fixed[free_slot]   = 1'b0;
                    end
                    hit = free_slot;
                end
                if (hit < 0)
                    res.status = STS_FULL;
                else
                    res.slot_index = hit[3:0];
            end
            ACT_REMOVE, ACT_FIND:
            begin
                hit = lookup_slot(addr);
                if (hit < 0)
                    res.status = STS_NOT_FOUND;
                else
                begin
                    res.slot_index = hit[3:0];
                    if (op == ACT_REMOVE)
                    begin
                        slot_address[hit] = '0;
                        slot_valid[hit]   = 1'b0;
                        slot_fixed[hit]   = 1'b0;
                        slot_rssi[hit]    = '0;
                    end
                end
            end
            ACT_CLEAR_ALL:
            begin
                foreach (slot_valid[i])
                    slot_valid[i] = 1'b0;
            end
            default:
            begin
                if (idx >= SLOTS)
                    res.status = STS_RANGE;
                else
                begin
                    res.slot_index = idx[3:0];
                    case (op)
                        ACT_SET_FIXED:
                        begin
                            slot_fixed[idx] = 1'b1;
                            slot_rssi[idx]  = rssi;
                        end
                        ACT_CLR_FIXED:
                            slot_fixed[idx] = 1'b0;
                        ACT_GET_FIXED:
                        begin
                            if (slot_valid[idx] && slot_fixed[idx])
                                res.entry_rssi = slot_rssi[idx];
                            else
                                res.status = STS_NO_FIXED;
                        end
                        default:
                        begin
                            res.entry_address = slot_address[idx];
                            res.entry_rssi    = slot_rssi[idx];
                            res.entry_valid   = slot_valid[idx];
                            res.entry_fixed   = slot_fixed[idx];
                        end
                    endcase
                end
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] random_address();
        return {$urandom, $urandom};
    endfunction

    // mostly pool addresses and in-range slots, some noise
    function automatic table_request_t random_request();
        table_request_t req;
        int unsigned    pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            req.op = ACT_ADD;
        else if (pick < 47)
            req.op = ACT_REMOVE;
        else if (pick < 62)
            req.op = ACT_FIND;
        else if (pick < 64)
            req.op = ACT_CLEAR_ALL;
        else if (pick < 72)
            req.op = ACT_SET_FIXED;
        else if (pick < 77)
            req.op = ACT_CLR_FIXED;
        else if (pick < 88)
            req.op = ACT_GET_FIXED;
        else
            req.op = ACT_READ_ENTRY;
        if ($urandom_range(0, 99) < 85)
            req.addr = address_pool[$urandom_range(0, address_pool.size() - 1)];
        else
            req.addr = random_address();
        if ($urandom_range(0, 99) < 85)
            req.idx = 8'($urandom_range(0, SLOTS - 1));
        else
            req.idx = 8'($urandom_range(0, 255));
        req.rssi        = 8'($urandom_range(0, 255));
        req.fixed_reply = 1'b0;
        req.reply       = '0;
        return req;
    endfunction

    // drive one request and wait for its acceptance; valid stays high after
    task automatic send_request(input table_request_t req);
        result_t predicted;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= req.op;
        in_ch.ext_address <= req.addr;
        in_ch.entry_index <= req.idx;
        in_ch.rssi_value  <= req.rssi;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // the mirror moves on every accepted request, typed rows included
        predicted = apply_table_op(req.op, req.addr, req.idx, req.rssi);
        table_replies.push_back(req.fixed_reply ? req.reply : predicted);
    endtask

    function automatic void check_field(string label, logic [63:0] want,
                                        logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, label, want, got);
            fault_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall bursts while idling is on
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (table_replies.size() == 0)
            begin
                $display("%0t: result with none pending, status %0h slot %0h",
                         $time, out_ch.status, out_ch.slot_index);
                fault_count++;
            end
            else
            begin
                want = table_replies.pop_front();
                check_field("status", want.status, out_ch.status);
                check_field("slot_index", want.slot_index, out_ch.slot_index);
                check_field("entry_address", want.entry_address,
                            out_ch.entry_address);
                check_field("entry_rssi", want.entry_rssi, out_ch.entry_rssi);
                check_field("entry_valid", want.entry_valid, out_ch.entry_valid);
                check_field("entry_fixed", want.entry_fixed, out_ch.entry_fixed);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
            $display("mac_address_filter_table_unit: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int unsigned sent;
        int unsigned pool_size;
        int unsigned run_len;
        bit          first_episode;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_FIND;
        in_ch.ext_address <= '0;
        in_ch.entry_index <= '0;
        in_ch.rssi_value  <= '0;
        rst_n             <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk, back to back
        foreach (directed_rows[i])
            send_request(directed_rows[i]);

        // random episodes over small address pools
        sent          = 0;
        first_episode = 1'b1;
        while (sent < RANDOM_ITEMS)
        begin
            // pools below, at and above the table size: full comes up often
            case ($urandom_range(0, 4))
                0:       pool_size = 3;
                1:       pool_size = 10;
                2:       pool_size = SLOTS;
                3:       pool_size = SLOTS + 1;
                default: pool_size = 24;
            endcase
            address_pool.delete();
            repeat (pool_size)
            begin
                case ($urandom_range(0, 7))
                    0:       address_pool.push_back(64'h0);
                    1:       address_pool.push_back(ADDR_ONES);
                    default: address_pool.push_back(random_address());
                endcase
            end
            idle_on = (sent + QUIET_TAIL < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);

            // hold off until the table has answered everything
            if (first_episode || $urandom_range(0, 2) == 0)
            begin
                in_ch.valid <= 1'b0;
                while (table_replies.size() != 0)
                    @(posedge clk);
                @(posedge clk);
                first_episode = 1'b0;
            end

            run_len = $urandom_range(60, 150);
            while (run_len != 0 && sent < RANDOM_ITEMS)
            begin
                if (sent + QUIET_TAIL >= RANDOM_ITEMS)
                    idle_on = 1'b0;
                if (idle_on && $urandom_range(0, 4) == 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                send_request(random_request());
                sent++;
                run_len--;
            end
        end
        in_ch.valid <= 1'b0;

        // drain, then watch a little longer for stray results
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("mac_address_filter_table_unit: match");
        else
            $display("mac_address_filter_table_unit: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
rtl/maft_pkg.sv
rtl/maft_if.sv
rtl/maft_mem.sv
rtl/maft_ctrl.sv
rtl/mac_address_filter_table_unit.sv
verif/tb_top.sv
